// ===== src/tlbf_pkg.sv =====
// shared constants, command codes and control/status types for the brightness fade block
`timescale 1ns / 1ps
package tlbf_pkg;

   localparam int TIME_BITS  = 32;
   localparam int LEVEL_BITS = 8;
   localparam int PROD_BITS  = TIME_BITS + LEVEL_BITS;
   localparam int CNT_BITS   = $clog2(LEVEL_BITS);

   // request tdata layout, lowest field first
   localparam int NOW_LSB       = 0;
   localparam int TARGET_LSB    = NOW_LSB + TIME_BITS;
   localparam int FADE_LSB      = TARGET_LSB + LEVEL_BITS;
   localparam int REQ_USED_BITS = FADE_LSB + TIME_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((LEVEL_BITS + 7) / 8) * 8;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic take_start;   // latch a new fade
      logic take_tick;    // latch elapsed time of a tick
      logic do_mul;       // form magnitude * elapsed, seed the divider
      logic div_step;     // one quotient bit
      logic commit_done;  // fade reached its end
      logic commit_ramp;  // apply quotient to the level
      logic load_out;     // move result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic fade_active;
      logic reached;
   } dp_status_type;

endpackage

// ===== src/timed_linear_brightness_fade_top.sv =====
// Linear brightness fade timed by a free-running millisecond clock.
//
// Request channel (req_): one item per handshake. tuser selects the kind:
// a start item records start time, target level and fade length and latches
// the present level as the starting level; a tick item carries the present
// time. Response channel (rsp_): tdata is the new duty level, tlast is high
// when the tick ended the fade at its target.
// A start item, and a tick while no fade is active, give no result; the
// block is ready again on the next cycle. A tick at or past the end of the
// fade goes from the evaluate state straight to the output state. Any other tick
// goes through a restoring divider (one quotient bit per cycle) after a
// multiply step, then a commit state, before the output state; in both
// cases the block turns ready in the same cycle as that result appears.
// Items are worked one at a time.
// The output register lets a new item be accepted while the last result
// waits; if the receiver still holds off when the next result is ready, the
// block waits with req_tready low until the output register frees up.
// Synchronous reset clears the levels, the fade state (no fade active) and
// the output valid.
`timescale 1ns / 1ps
module timed_linear_brightness_fade_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_time, target_value, fade_time (lowest first)
   input  logic [tlbf_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // cmd
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // duty
   output logic [tlbf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);

   tlbf_pkg::ctrl_cmd_type          ctrl_cmd;
   tlbf_pkg::dp_status_type         status;
   tlbf_pkg::cmd_type               req_cmd;
   logic [tlbf_pkg::LEVEL_BITS-1:0] duty;

   assign req_cmd = tlbf_pkg::cmd_type'(req_tuser);

   tlbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctrl_cmd   (ctrl_cmd)
   );

   tlbf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl_cmd      (ctrl_cmd),
      .status        (status),
      .now_time      (req_tdata[tlbf_pkg::NOW_LSB +: tlbf_pkg::TIME_BITS]),
      .target_value  (req_tdata[tlbf_pkg::TARGET_LSB +: tlbf_pkg::LEVEL_BITS]),
      .fade_time     (req_tdata[tlbf_pkg::FADE_LSB +: tlbf_pkg::TIME_BITS]),
      .duty          (duty),
      .fade_finished (rsp_tlast)
   );

   assign rsp_tdata = tlbf_pkg::RSP_DATA_BITS'(duty);

endmodule

// ===== src/tlbf_dp.sv =====
// fade datapath: fade state, elapsed time, multiplier, restoring divider and output register
`timescale 1ns / 1ps
module tlbf_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tlbf_pkg::ctrl_cmd_type                  ctrl_cmd,
   output tlbf_pkg::dp_status_type                 status,
   input  logic [tlbf_pkg::TIME_BITS-1:0]          now_time,
   input  logic [tlbf_pkg::LEVEL_BITS-1:0]         target_value,
   input  logic [tlbf_pkg::TIME_BITS-1:0]          fade_time,
   output logic [tlbf_pkg::LEVEL_BITS-1:0]         duty,
   output logic                                    fade_finished
);

   logic [tlbf_pkg::LEVEL_BITS-1:0] level_now_ff, level_now_in;
   logic [tlbf_pkg::LEVEL_BITS-1:0] level_from_ff, level_from_in;
   logic [tlbf_pkg::LEVEL_BITS-1:0] level_to_ff, level_to_in;
   logic [tlbf_pkg::TIME_BITS-1:0]  fade_start_ff, fade_start_in;
   logic [tlbf_pkg::TIME_BITS-1:0]  fade_length_ff, fade_length_in;

   logic [tlbf_pkg::TIME_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [tlbf_pkg::TIME_BITS-1:0]  rem_ff, rem_in;
   logic [tlbf_pkg::LEVEL_BITS-1:0] lo_ff, lo_in;
   logic [tlbf_pkg::LEVEL_BITS-1:0] quot_ff, quot_in;
   logic                            res_fin_ff, res_fin_in;
   logic [tlbf_pkg::LEVEL_BITS-1:0] duty_ff, duty_in;
   logic                            fin_ff, fin_in;

   logic                            up;
   logic [tlbf_pkg::LEVEL_BITS-1:0] mag;
   logic [tlbf_pkg::PROD_BITS-1:0]  product;
   logic [tlbf_pkg::TIME_BITS:0]    trial;
   logic                            fits;
   logic [tlbf_pkg::TIME_BITS-1:0]  rem_step;
   logic [tlbf_pkg::LEVEL_BITS-1:0] ramp_level;

   always_comb begin
      up      = level_to_ff >= level_from_ff;
      mag     = up ? level_to_ff - level_from_ff : level_from_ff - level_to_ff;
      product = tlbf_pkg::PROD_BITS'(mag) * tlbf_pkg::PROD_BITS'(elapsed_ff);

      // restoring step: shift in the next product bit, subtract length if it fits
      trial    = {rem_ff, lo_ff[tlbf_pkg::LEVEL_BITS-1]};
      fits     = trial >= {1'b0, fade_length_ff};
      rem_step = fits ? tlbf_pkg::TIME_BITS'(trial - {1'b0, fade_length_ff})
                      : trial[tlbf_pkg::TIME_BITS-1:0];

      ramp_level = up ? level_from_ff + quot_ff : level_from_ff - quot_ff;

      status.fade_active = fade_length_ff != '0;
      status.reached     = elapsed_ff >= fade_length_ff;

      level_now_in   = level_now_ff;
      level_from_in  = level_from_ff;
      level_to_in    = level_to_ff;
      fade_start_in  = fade_start_ff;
      fade_length_in = fade_length_ff;
      elapsed_in     = elapsed_ff;
      rem_in         = rem_ff;
      lo_in          = lo_ff;
      quot_in        = quot_ff;
      res_fin_in     = res_fin_ff;
      duty_in        = duty_ff;
      fin_in         = fin_ff;

      if (ctrl_cmd.take_start) begin
         fade_start_in  = now_time;
         fade_length_in = fade_time;
         level_to_in    = target_value;
         level_from_in  = level_now_ff;
      end
      if (ctrl_cmd.take_tick) begin
         elapsed_in = now_time - fade_start_ff;
      end
      if (ctrl_cmd.do_mul) begin
         // product < length * 2^LEVEL_BITS, so the upper part starts below length
         rem_in  = product[tlbf_pkg::PROD_BITS-1:tlbf_pkg::LEVEL_BITS];
         lo_in   = product[tlbf_pkg::LEVEL_BITS-1:0];
         quot_in = '0;
      end
      if (ctrl_cmd.div_step) begin
         rem_in  = rem_step;
         lo_in   = {lo_ff[tlbf_pkg::LEVEL_BITS-2:0], 1'b0};
         quot_in = {quot_ff[tlbf_pkg::LEVEL_BITS-2:0], fits};
      end
      if (ctrl_cmd.commit_done) begin
         level_now_in   = level_to_ff;
         fade_length_in = '0;
         res_fin_in     = 1'b1;
      end
      if (ctrl_cmd.commit_ramp) begin
         level_now_in = ramp_level;
         res_fin_in   = 1'b0;
      end
      if (ctrl_cmd.load_out) begin
         duty_in = level_now_ff;
         fin_in  = res_fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_now_ff   <= '0;
         level_from_ff  <= '0;
         level_to_ff    <= '0;
         fade_start_ff  <= '0;
         fade_length_ff <= '0;
      end else begin
         level_now_ff   <= level_now_in;
         level_from_ff  <= level_from_in;
         level_to_ff    <= level_to_in;
         fade_start_ff  <= fade_start_in;
         fade_length_ff <= fade_length_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      rem_ff     <= rem_in;
      lo_ff      <= lo_in;
      quot_ff    <= quot_in;
      res_fin_ff <= res_fin_in;
      duty_ff    <= duty_in;
      fin_ff     <= fin_in;
   end

   assign duty          = duty_ff;
   assign fade_finished = fin_ff;

endmodule

// ===== src/tlbf_ctrl.sv =====
// fade controller: sequences accept, compare, multiply, divide and result hand-off
`timescale 1ns / 1ps
module tlbf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  tlbf_pkg::cmd_type       req_cmd,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  tlbf_pkg::dp_status_type status,
   output tlbf_pkg::ctrl_cmd_type  ctrl_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_COMMIT,
      ST_OUT
   } state_type;

   state_type                     state_ff, state_in;
   logic [tlbf_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                          valid_ff, valid_in;
   logic                          out_free;

   always_comb begin
      out_free = !valid_ff || rsp_tready;

      ctrl_cmd   = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            // ready is always high here, so valid alone marks an accepted item
            if (req_tvalid) begin
               if (req_cmd == tlbf_pkg::CMD_START) begin
                  ctrl_cmd.take_start = 1'b1;
               end else if (status.fade_active) begin
                  ctrl_cmd.take_tick = 1'b1;
                  state_in           = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (status.reached) begin
               ctrl_cmd.commit_done = 1'b1;
               state_in             = ST_OUT;
            end else begin
               ctrl_cmd.do_mul = 1'b1;
               cnt_in          = tlbf_pkg::CNT_BITS'(tlbf_pkg::LEVEL_BITS - 1);
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            ctrl_cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_COMMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_COMMIT: begin
            ctrl_cmd.commit_ramp = 1'b1;
            state_in             = ST_OUT;
         end
         ST_OUT: begin
            // wait here only while the previous item is still unclaimed
            if (out_free) begin
               ctrl_cmd.load_out = 1'b1;
               valid_in          = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ===== src/tlbf_checker.sv =====
// port-level checks for the brightness fade block, bound to the top level
`timescale 1ns / 1ps
module tlbf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tlbf_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast
);

   // a stalled item holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response item changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a start item never gives a result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == tlbf_pkg::CMD_START && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("start item produced a result");

   // a result is only produced while the block is busy with a tick
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while idle");

endmodule

bind timed_linear_brightness_fade_top tlbf_checker u_tlbf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the timed linear brightness fade block
`timescale 1ns / 1ps
module testbench;

   typedef logic [tlbf_pkg::TIME_BITS-1:0]  stamp_type;
   typedef logic [tlbf_pkg::LEVEL_BITS-1:0] level_type;

   typedef struct {
      tlbf_pkg::cmd_type cmd;
      stamp_type         now;
      level_type         target;
      stamp_type         length;
      bit                drain_first;
   } fade_item_type;

   typedef struct {
      level_type duty;
      logic      finished;
   } duty_result_type;

   localparam int CYCLE_LIMIT = 400000;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [tlbf_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                               req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [tlbf_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tlast;

   fade_item_type   fade_items[$];
   duty_result_type duty_expected[$];
   int              seen_count;
   int              accepted_count;
   int              cycle_count;
   int              errors;

   // fade state as the block should hold it
   level_type lvl_now, lvl_from, lvl_to;
   stamp_type fade_t0, fade_len;

   timed_linear_brightness_fade_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic add_start(input stamp_type now, input level_type target,
                            input stamp_type length);
      fade_item_type it;
      it.cmd         = tlbf_pkg::CMD_START;
      it.now         = now;
      it.target      = target;
      it.length      = length;
      it.drain_first = 1'b0;
      fade_items.push_back(it);
   endtask

   task automatic add_tick(input stamp_type now);
      fade_item_type it;
      it.cmd         = tlbf_pkg::CMD_TICK;
      it.now         = now;
      it.target      = level_type'($urandom);
      it.length      = stamp_type'($urandom);
      it.drain_first = 1'b0;
      fade_items.push_back(it);
   endtask

   task automatic predict_fade(input tlbf_pkg::cmd_type cmd, input stamp_type now,
                               input level_type target, input stamp_type length);
      stamp_type       elapsed;
      longint unsigned mag;
      longint unsigned step;
      duty_result_type res;
      if (cmd == tlbf_pkg::CMD_START) begin
         fade_t0  = now;
         fade_len = length;
         lvl_to   = target;
         lvl_from = lvl_now;
      end else if (fade_len != '0) begin
         elapsed = now - fade_t0;
         if (elapsed >= fade_len) begin
            lvl_now      = lvl_to;
            fade_len     = '0;
            res.finished = 1'b1;
         end else begin
            res.finished = 1'b0;
            if (lvl_to >= lvl_from) begin
               mag     = lvl_to - lvl_from;
               step    = (mag * elapsed) / fade_len;
               lvl_now = lvl_from + level_type'(step);
            end else begin
               mag     = lvl_from - lvl_to;
               step    = (mag * elapsed) / fade_len;
               lvl_now = lvl_from - level_type'(step);
            end
         end
         res.duty = lvl_now;
         duty_expected.push_back(res);
      end
   endtask

   // driver
   always @(negedge clock) begin
      logic                               valid_next;
      logic [tlbf_pkg::REQ_DATA_BITS-1:0] packed_data;
      fade_item_type                      it;
      bit                                 no_idle;
      no_idle = accepted_count >= 400 && accepted_count < 600;
      if (!reset) begin
         // an item still shown is dropped once the monitor has counted it
         valid_next = req_tvalid && seen_count == accepted_count;
         seen_count = accepted_count;
         if (!valid_next && fade_items.size() > 0) begin
            if (fade_items[0].drain_first && duty_expected.size() != 0) begin
               valid_next = 1'b0;
            end else if (no_idle || $urandom_range(99) >= 33) begin
               it          = fade_items.pop_front();
               packed_data = '0;
               packed_data[tlbf_pkg::NOW_LSB +: tlbf_pkg::TIME_BITS]     = it.now;
               packed_data[tlbf_pkg::TARGET_LSB +: tlbf_pkg::LEVEL_BITS] = it.target;
               packed_data[tlbf_pkg::FADE_LSB +: tlbf_pkg::TIME_BITS]    = it.length;
               req_tdata  <= packed_data;
               req_tuser  <= it.cmd;
               valid_next = 1'b1;
            end
         end
         req_tvalid <= valid_next;
         rsp_tready <= no_idle || $urandom_range(99) >= 33;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      duty_result_type exp_res;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (duty_expected.size() == 0) begin
               errors++;
               $display("%0t unexpected item: expected none actual duty %0d done %0b",
                        $time, rsp_tdata[tlbf_pkg::LEVEL_BITS-1:0], rsp_tlast);
            end else begin
               exp_res = duty_expected.pop_front();
               if (rsp_tdata[tlbf_pkg::LEVEL_BITS-1:0] !== exp_res.duty) begin
                  errors++;
                  $display("%0t duty mismatch: expected %0d actual %0d",
                           $time, exp_res.duty, rsp_tdata[tlbf_pkg::LEVEL_BITS-1:0]);
               end
               if (rsp_tlast !== exp_res.finished) begin
                  errors++;
                  $display("%0t done flag mismatch: expected %0b actual %0b",
                           $time, exp_res.finished, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_fade(tlbf_pkg::cmd_type'(req_tuser),
                         req_tdata[tlbf_pkg::NOW_LSB +: tlbf_pkg::TIME_BITS],
                         req_tdata[tlbf_pkg::TARGET_LSB +: tlbf_pkg::LEVEL_BITS],
                         req_tdata[tlbf_pkg::FADE_LSB +: tlbf_pkg::TIME_BITS]);
            accepted_count++;
         end
      end
   end

   initial begin
      stamp_type       t0;
      stamp_type       t;
      stamp_type       length;
      longint unsigned stride;
      int              ticks;
      int              mode;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      rsp_tready     = 1'b0;
      seen_count     = 0;
      accepted_count = 0;
      cycle_count    = 0;
      errors         = 0;
      lvl_now        = '0;
      lvl_from       = '0;
      lvl_to         = '0;
      fade_t0        = '0;
      fade_len       = '0;

      // tick with no fade, then a zero-length fade
      add_tick(32'd5);
      add_start(32'd100, 8'd200, 32'd0);
      add_tick(32'd150);
      // full upward ramp, finish, then a tick after the end
      add_start(32'd1000, 8'd255, 32'd100);
      add_tick(32'd1000);
      add_tick(32'd1050);
      add_tick(32'd1099);
      add_tick(32'd1100);
      add_tick(32'd1200);
      // downward ramp across the time wrap
      add_start(32'hFFFF_FFF0, 8'd0, 32'h40);
      add_tick(32'h10);
      // restart mid-fade, then a tick earlier than the start time
      add_start(32'd5000, 8'd200, 32'd1000);
      add_tick(32'd4999);
      // longest fade
      add_start(32'd0, 8'd0, 32'hFFFF_FFFF);
      add_tick(32'hFFFF_FFFE);
      add_tick(32'hFFFF_FFFF);
      // shortest fade at the top of the clock
      add_start(32'hFFFF_FFFF, 8'd255, 32'd1);
      add_tick(32'hFFFF_FFFF);
      add_tick(32'd0);

      while (fade_items.size() < 1050) begin
         if (fade_items.size() % 200 == 0)
            fade_items[fade_items.size()-1].drain_first = 1'b1;
         mode = $urandom_range(9);
         if (mode < 8) begin
            t0 = stamp_type'($urandom);
            case ($urandom_range(3))
               0: length = stamp_type'($urandom_range(1, 20));
               1: length = stamp_type'($urandom_range(1, 5000));
               2: length = stamp_type'($urandom);
               default: length = stamp_type'($urandom_range(0, 3));
            endcase
            add_start(t0, level_type'($urandom), length);
            ticks = $urandom_range(1, 8);
            t     = t0;
            for (int k = 0; k < ticks; k++) begin
               stride = (longint'(length) * $urandom_range(0, 250)) / (100 * ticks);
               t      = t + stamp_type'(stride);
               add_tick(t);
            end
         end else begin
            if ($urandom_range(1))
               add_tick(stamp_type'($urandom));
            else
               add_start(stamp_type'($urandom), level_type'($urandom),
                         stamp_type'($urandom));
         end
      end
      fade_items[25].drain_first = 1'b1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (fade_items.size() == 0 && !req_tvalid);
      wait (duty_expected.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && duty_expected.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tlbf_pkg.sv
src/tlbf_dp.sv
src/tlbf_ctrl.sv
src/timed_linear_brightness_fade_top.sv
src/tlbf_checker.sv
tb/testbench.sv
